// File: src/mlfd_pkg.sv
// Shared types and constants for the marker and length frame deframer.
// Used by mlfd_core, mlfd_obuf and marker_length_frame_deframer.
package mlfd_pkg;

  localparam int MARKER_MAX_DEF = 4;
  localparam int HEADER_BYTES   = 5;
  localparam int BSM_W          = 17;
  localparam int LEN_W          = 16;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 32;

  localparam logic [LEN_W-1:0] PAYLOAD_LIMIT_RST = 16'd1024;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_HEADER,
    PH_BODY
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MARKER_BYTES,
    CFG_MARKER_LENGTH,
    CFG_TRAILER_LENGTH,
    CFG_PAYLOAD_LIMIT
  } cfg_idx_t;

  typedef enum logic {
    OP_BYTE,
    OP_TIMEOUT
  } op_t;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
    logic       last;
    logic       abort;
  } res_t;

endpackage

// File: src/mlfd_core.sv
// Frame tracking logic: configuration registers, marker hunt, header decode
// and body count. Produces up to DEPTH results per accepted item. Uses mlfd_pkg.
module mlfd_core #(
  parameter int MARKER_MAX = mlfd_pkg::MARKER_MAX_DEF,
  parameter int DEPTH      = (MARKER_MAX < 4) ? MARKER_MAX : 4,
  parameter int CW         = $clog2(DEPTH + 1)
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_we,
  input  logic [mlfd_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [mlfd_pkg::CFG_DATA_W-1:0]         cfg_data,
  input  logic                                    accept,
  input  logic                                    op,
  input  logic [7:0]                              data_byte,
  output mlfd_pkg::res_t [DEPTH-1:0]              res,
  output logic [CW-1:0]                           res_cnt
);
  import mlfd_pkg::*;

  // Configuration registers.
  logic [31:0]      marker_bytes;
  logic [2:0]       marker_length;
  logic [2:0]       trailer_length;
  logic [LEN_W-1:0] payload_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      marker_bytes   <= '0;
      marker_length  <= '0;
      trailer_length <= '0;
      payload_limit  <= PAYLOAD_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MARKER_BYTES:   marker_bytes   <= cfg_data;
        CFG_MARKER_LENGTH:  marker_length  <= cfg_data[2:0];
        CFG_TRAILER_LENGTH: trailer_length <= cfg_data[2:0];
        CFG_PAYLOAD_LIMIT:  payload_limit  <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Frame state.
  phase_t               phase, phase_next;
  logic [DEPTH-1:0][7:0] window, window_next;
  logic [CW-1:0]        fill, fill_next;
  logic [BSM_W-1:0]     bsm, bsm_next;
  logic [7:0]           len_lo, len_lo_next;
  logic [LEN_W-1:0]     plen, plen_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_HUNT;
      window <= '0;
      fill   <= '0;
      bsm    <= '0;
      len_lo <= '0;
      plen   <= '0;
    end else begin
      phase  <= phase_next;
      window <= window_next;
      fill   <= fill_next;
      bsm    <= bsm_next;
      len_lo <= len_lo_next;
      plen   <= plen_next;
    end
  end

  logic [CW-1:0]          eff_len;
  logic [CW-1:0]          fill_c;
  logic [DEPTH:0][7:0]    win_ext;
  logic [DEPTH-1:0][7:0]  hunt_win;
  logic [CW-1:0]          hunt_fill;
  logic                   hunt_match;
  logic [LEN_W-1:0]       hdr_len;
  logic [BSM_W-1:0]       body_cnt;
  logic [BSM_W-1:0]       body_total;

  assign eff_len = (marker_length > 3'(DEPTH)) ? CW'(DEPTH) : CW'(marker_length);
  assign fill_c  = (fill > eff_len) ? eff_len : fill;
  assign win_ext = {8'h00, window};

  // Window update, one lane per marker byte position.
  always_comb begin
    hunt_match = (fill_c >= eff_len) || (fill_c + CW'(1) == eff_len);
    for (int i = 0; i < DEPTH; i++) begin
      if (CW'(i) >= eff_len) begin
        hunt_win[i] = 8'h00;
      end else if (fill_c < eff_len) begin
        hunt_win[i] = (CW'(i) == fill_c) ? (window[i] | data_byte) : window[i];
      end else if (CW'(i) == eff_len - CW'(1)) begin
        hunt_win[i] = data_byte;
      end else begin
        hunt_win[i] = win_ext[i+1];
      end
      if (CW'(i) < eff_len && hunt_win[i] != marker_bytes[8*i +: 8]) begin
        hunt_match = 1'b0;
      end
    end
  end

  assign hunt_fill  = (fill_c < eff_len) ? fill_c + CW'(1) : fill_c;
  assign hdr_len    = {data_byte, len_lo};
  assign body_cnt   = bsm + BSM_W'(1);
  assign body_total = BSM_W'(HEADER_BYTES) + BSM_W'(plen) + BSM_W'(trailer_length);

  always_comb begin
    phase_next  = phase;
    window_next = window;
    fill_next   = fill;
    bsm_next    = bsm;
    len_lo_next = len_lo;
    plen_next   = plen;
    res         = '0;
    res_cnt     = '0;

    if (accept) begin
      if (op_t'(op) == OP_TIMEOUT) begin
        if (phase == PH_BODY || (phase == PH_HEADER && bsm != '0)) begin
          phase_next  = PH_HUNT;
          window_next = '0;
          fill_next   = '0;
          bsm_next    = '0;
          res[0].abort = 1'b1;
          res_cnt     = CW'(1);
        end
      end else begin
        unique case (phase)
          PH_HEADER: begin
            if (bsm == BSM_W'(HEADER_BYTES - 2)) begin
              len_lo_next = data_byte;
            end
            if (bsm >= BSM_W'(HEADER_BYTES - 1)) begin
              plen_next = hdr_len;
              res_cnt   = CW'(1);
              if (hdr_len > payload_limit) begin
                phase_next   = PH_HUNT;
                window_next  = '0;
                fill_next    = '0;
                bsm_next     = '0;
                res[0].abort = 1'b1;
              end else if (hdr_len == '0 && trailer_length == '0) begin
                phase_next   = PH_HUNT;
                window_next  = '0;
                fill_next    = '0;
                bsm_next     = '0;
                res[0].data  = data_byte;
                res[0].last  = 1'b1;
              end else begin
                phase_next  = PH_BODY;
                bsm_next    = BSM_W'(HEADER_BYTES);
                res[0].data = data_byte;
              end
            end else begin
              bsm_next    = bsm + BSM_W'(1);
              res[0].data = data_byte;
              res_cnt     = CW'(1);
            end
          end
          PH_BODY: begin
            res[0].data = data_byte;
            res_cnt     = CW'(1);
            if (body_cnt >= body_total) begin
              res[0].last = 1'b1;
              phase_next  = PH_HUNT;
              window_next = '0;
              fill_next   = '0;
              bsm_next    = '0;
            end else begin
              bsm_next = body_cnt;
            end
          end
          default: begin
            // With no marker configured any byte opens a frame as header byte 0.
            if (eff_len == '0) begin
              res[0].data  = data_byte;
              res[0].start = 1'b1;
              res_cnt      = CW'(1);
              bsm_next     = BSM_W'(1);
              phase_next   = PH_HEADER;
            end else if (hunt_match) begin
              for (int i = 0; i < DEPTH; i++) begin
                res[i].data  = marker_bytes[8*i +: 8];
                res[i].start = (i == 0);
              end
              res_cnt     = eff_len;
              window_next = '0;
              fill_next   = '0;
              bsm_next    = '0;
              phase_next  = PH_HEADER;
            end else begin
              window_next = hunt_win;
              fill_next   = hunt_fill;
              phase_next  = PH_HUNT;
            end
          end
        endcase
      end
    end

    // A new marker setting restarts the hunt from an empty window.
    if (cfg_we && (cfg_idx_t'(cfg_index) == CFG_MARKER_BYTES ||
                   cfg_idx_t'(cfg_index) == CFG_MARKER_LENGTH)) begin
      window_next = '0;
      fill_next   = '0;
    end
  end

`ifndef SYNTHESIS
  a_timeout_aborts_body: assert property (@(posedge clk) disable iff (rst)
    (accept && op_t'(op) == OP_TIMEOUT && phase == PH_BODY) |=> (phase == PH_HUNT))
    else $error("timeout in frame body did not return to hunting");

  a_header_count: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_HEADER) |-> (bsm < BSM_W'(HEADER_BYTES)))
    else $error("header byte count out of range");

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(DEPTH))
    else $error("marker window fill exceeds window size");
`endif

endmodule

// File: src/mlfd_obuf.sv
// Result buffer: holds the results of one item and hands them out one per
// transfer, oldest first. Uses mlfd_pkg for the result type.
module mlfd_obuf #(
  parameter int DEPTH = 4,
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  mlfd_pkg::res_t [DEPTH-1:0]   ld_res,
  input  logic [CW-1:0]                ld_cnt,
  output logic                         in_ready,
  output logic                         out_valid,
  input  logic                         out_ready,
  output mlfd_pkg::res_t               out_res
);
  import mlfd_pkg::*;

  res_t [DEPTH-1:0] ent;
  logic [CW-1:0]    cnt;
  logic             pop;
  logic             load;

  assign pop       = (cnt != '0) && out_ready;
  assign load      = accept && (ld_cnt != '0);
  assign in_ready  = (cnt == '0) || (cnt == CW'(1) && out_ready);
  assign out_valid = (cnt != '0);
  assign out_res   = ent[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= ld_cnt;
    end else if (pop) begin
      cnt <= cnt - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ent <= ld_res;
    end else if (pop) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        ent[i] <= ent[i+1];
      end
    end
  end

endmodule

// File: src/marker_length_frame_deframer.sv
// Results are registered in the result buffer; input waits while they drain.
// Throughput: one byte per cycle while m_tready is high; a found marker gives
// marker_length results (at most DEPTH), one per cycle while m_tready is high.
// Reset (rst, synchronous): hunting with an empty window, buffer empty,
// payload_limit 1024 and all other core registers zero.
module marker_length_frame_deframer #(
  parameter int MARKER_MAX = mlfd_pkg::MARKER_MAX_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [mlfd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mlfd_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [7:0]                       s_tdata,   // data_byte
  input  logic                             s_tuser,   // operation
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [7:0]                       m_tdata,   // out_byte
  output logic                             m_tlast,   // frame_end
  output logic [1:0]                       m_tuser    // {frame_abort, frame_start}
);
  import mlfd_pkg::*;

  localparam int DEPTH = (MARKER_MAX < 4) ? MARKER_MAX : 4;
  localparam int CW    = $clog2(DEPTH + 1);

  res_t [DEPTH-1:0] res;
  logic [CW-1:0]    res_cnt;
  res_t             out_res;
  logic             accept;

  assign accept = s_tvalid && s_tready;

  mlfd_core #(
    .MARKER_MAX(MARKER_MAX),
    .DEPTH     (DEPTH),
    .CW        (CW)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .accept   (accept),
    .op       (s_tuser),
    .data_byte(s_tdata),
    .res      (res),
    .res_cnt  (res_cnt)
  );

  mlfd_obuf #(
    .DEPTH(DEPTH),
    .CW   (CW)
  ) u_obuf (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .ld_res   (res),
    .ld_cnt   (res_cnt),
    .in_ready (s_tready),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_res  (out_res)
  );

  assign m_tdata = out_res.data;
  assign m_tlast = out_res.last;
  assign m_tuser = {out_res.abort, out_res.start};

endmodule
